// File: src/tbah_pkg.sv
// Shared constants and types for the time-binned average history block.
`timescale 1ns / 1ps

package tbah_pkg;

    // Field widths
    localparam int TIME_W    = 32;
    localparam int VALUE_W   = 16;
    localparam int SLOT_W    = 5;
    localparam int BINSEC_W  = 8;
    localparam int SUM_W     = 32;
    localparam int COUNT_W   = 16;

    // Shared serial divider: 32-bit dividend, 16-bit divisor, one bit a step
    localparam int DIVIDEND_W = 32;
    localparam int DIVISOR_W  = 16;
    localparam int DIV_STEPS  = DIVIDEND_W;
    localparam int DIV_CNT_W  = $clog2(DIV_STEPS);

    // Default history depth
    localparam int HISTORY_POINTS_DEF = 32;

    // Reset values
    localparam logic [BINSEC_W-1:0] BIN_SECONDS_RESET = 8'd30;

    typedef logic signed [VALUE_W-1:0] t_value;

    localparam t_value RESET_MARKER = 16'sh8000;

    // Command actions
    typedef logic t_action;
    localparam t_action ACT_SAMPLE = 1'b0;
    localparam t_action ACT_READ   = 1'b1;

    // Configuration register indexes
    typedef logic [0:0] t_cfg_index;
    localparam t_cfg_index CFG_BIN_SECONDS  = 1'b0;
    localparam t_cfg_index CFG_UNDEF_MARKER = 1'b1;

endpackage

// File: src/tbah_div.sv
// Shared restoring divider: one quotient bit per clock cycle.
`timescale 1ns / 1ps

module tbah_div
    import tbah_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_start,
    input  logic [DIVIDEND_W-1:0] i_dividend,
    input  logic [DIVISOR_W-1:0]  i_divisor,
    output logic [DIVIDEND_W-1:0] o_quotient,
    output logic                  o_done
);

    logic                  r_run;
    logic                  r_done;
    logic [DIV_CNT_W-1:0]  r_cnt;
    logic [DIVISOR_W-1:0]  r_rem;
    logic [DIVISOR_W-1:0]  r_dvs;
    logic [DIVIDEND_W-1:0] r_quo;

    logic [DIVISOR_W:0]    w_trial;
    logic                  w_fit;
    logic [DIVISOR_W:0]    w_diff;

    // Trial subtraction for the current bit
    assign w_trial = {r_rem, r_quo[DIVIDEND_W-1]};
    assign w_fit   = w_trial >= {1'b0, r_dvs};
    assign w_diff  = w_trial - {1'b0, r_dvs};

    // Step control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run  <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_run <= 1'b1;
                r_cnt <= '0;
            end else if (r_run) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == DIV_CNT_W'(DIV_STEPS - 1)) begin
                    r_run  <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // Datapath: remainder and quotient shift together
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= '0;
            r_quo <= i_dividend;
            r_dvs <= i_divisor;
        end else if (r_run) begin
            r_rem <= w_fit ? w_diff[DIVISOR_W-1:0] : w_trial[DIVISOR_W-1:0];
            r_quo <= {r_quo[DIVIDEND_W-2:0], w_fit};
        end
    end

    assign o_quotient = r_quo;
    assign o_done     = r_done;

endmodule

// File: src/tbah_hist.sv
// History store: one write and one registered read per cycle, valid bit per entry.
`timescale 1ns / 1ps

module tbah_hist
    import tbah_pkg::*;
#(
    parameter int HISTORY_POINTS = HISTORY_POINTS_DEF,
    localparam int IW = $clog2(HISTORY_POINTS)
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic [IW-1:0] i_rd_addr,
    input  logic          i_wr_en,
    input  logic [IW-1:0] i_wr_addr,
    input  t_value        i_wr_data,
    output t_value        o_rd_data
);

    t_value                    r_mem [HISTORY_POINTS];
    logic [HISTORY_POINTS-1:0] r_valid;
    t_value                    r_q;
    logic                      r_qv;

    // Storage array and registered read
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        r_q <= r_mem[i_rd_addr];
    end

    // Entry valid bits; an entry never written reads as the reset marker
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
            r_qv    <= 1'b0;
        end else begin
            if (i_wr_en) begin
                r_valid[i_wr_addr] <= 1'b1;
            end
            r_qv <= r_valid[i_rd_addr];
        end
    end

    assign o_rd_data = r_qv ? r_q : RESET_MARKER;

endmodule

// File: src/time_binned_average_history.sv
// Top level: command interface, configuration registers and the item sequencer.
`timescale 1ns / 1ps

// A command is taken when start is high and busy is low; each command gives
// exactly one result, shown for one cycle with o_result_strobe, and the
// receiver cannot stall it. A sample runs two 32-step divisions on one
// shared serial divider (bin number, then average) and, when the history
// slides, copies one entry per cycle through the history store's read and
// write ports. No clearing pass is needed after reset. The configuration
// port is always ready; the user must write it only while the block is
// idle, and the block itself does not enforce this.
module time_binned_average_history
    import tbah_pkg::*;
#(
    parameter int HISTORY_POINTS = HISTORY_POINTS_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    // Command channel
    input  logic                start,
    output logic                busy,
    input  logic                i_action,
    input  logic [TIME_W-1:0]   i_time_sec,
    input  t_value              i_sample_value,
    input  logic [SLOT_W-1:0]   i_read_slot,
    // Result channel
    output logic                o_result_strobe,
    output logic [SLOT_W-1:0]   o_slot,
    output t_value              o_point_value,
    output logic                o_point_valid,
    output logic [SLOT_W-1:0]   o_shifted_by,
    // Configuration channel
    input  logic                i_cfg_valid,
    output logic                o_cfg_ready,
    input  t_cfg_index          i_cfg_index,
    input  logic [VALUE_W-1:0]  i_cfg_data
);

    localparam int IW = $clog2(HISTORY_POINTS);
    localparam logic [IW:0]   HP_EXT   = (IW+1)'(HISTORY_POINTS);
    localparam logic [IW-1:0] LAST_IDX = IW'(HISTORY_POINTS - 1);
    localparam logic [IW-1:0] COPY_END = IW'(HISTORY_POINTS - 2);

    // Sequencer states
    localparam logic [2:0] S_IDLE    = 3'd0;
    localparam logic [2:0] S_RDOUT   = 3'd1;
    localparam logic [2:0] S_DIV_BIN = 3'd2;
    localparam logic [2:0] S_BIN     = 3'd3;
    localparam logic [2:0] S_SHIFT   = 3'd4;
    localparam logic [2:0] S_ACC     = 3'd5;
    localparam logic [2:0] S_MAG     = 3'd6;
    localparam logic [2:0] S_DIV_AVG = 3'd7;

    logic [2:0]             r_state;

    // Configuration
    logic [BINSEC_W-1:0]    r_bin_seconds;
    t_value                 r_marker;

    // Running state
    logic                   r_started;
    logic [TIME_W-1:0]      r_origin;
    logic [TIME_W-1:0]      r_prev_bin;
    logic signed [SUM_W-1:0] r_sum;
    logic [COUNT_W-1:0]     r_count;

    // Per-item working registers
    t_value                 r_value;
    logic [TIME_W-1:0]      r_bin;
    logic [IW-1:0]          r_shift;
    logic [IW-1:0]          r_slot;
    logic [IW-1:0]          r_idx;
    logic                   r_neg;
    logic [SLOT_W-1:0]      r_rd_slot;
    logic                   r_rd_oor;

    // Pending copy write during a slide
    logic                   r_cp_vld;
    logic                   r_cp_fill;
    logic [IW-1:0]          r_cp_dst;

    // Result registers
    logic                   r_out_stb;
    logic [SLOT_W-1:0]      r_out_slot;
    t_value                 r_out_value;
    logic                   r_out_valid;
    logic [SLOT_W-1:0]      r_out_shift;

    // Combinational
    logic                   w_accept;
    logic [BINSEC_W-1:0]    w_dur;
    logic [TIME_W-1:0]      w_elapsed;
    logic                   w_adv;
    logic                   w_wide;
    logic [TIME_W-1:0]      w_diff;
    logic [IW-1:0]          w_shift;
    logic [IW:0]            w_src;
    logic                   w_src_in;
    logic [SUM_W-1:0]       w_mag;
    logic [VALUE_W-1:0]     w_q16;
    t_value                 w_avg;
    t_value                 w_rd_value;
    logic                   w_div_start;
    logic [DIVIDEND_W-1:0]  w_div_a;
    logic [DIVISOR_W-1:0]   w_div_b;
    logic [DIVIDEND_W-1:0]  w_div_q;
    logic                   w_div_done;
    logic [IW-1:0]          w_rd_addr;
    logic                   w_wr_en;
    logic [IW-1:0]          w_wr_addr;
    t_value                 w_wr_data;
    logic                   w_avg_done;

    assign busy        = r_state != S_IDLE;
    assign w_accept    = start && !busy;
    assign o_cfg_ready = 1'b1;

    // Bin duration of zero acts as one second
    assign w_dur     = (r_bin_seconds == '0) ? BINSEC_W'(1) : r_bin_seconds;
    assign w_elapsed = i_time_sec - (r_started ? r_origin : i_time_sec);

    // Bin advance and slide amount
    assign w_adv   = r_bin > r_prev_bin;
    assign w_wide  = r_bin >= TIME_W'(HISTORY_POINTS);
    assign w_diff  = r_bin - r_prev_bin;
    assign w_shift = (w_diff > TIME_W'(HISTORY_POINTS - 1)) ? LAST_IDX : w_diff[IW-1:0];

    // Slide source index
    assign w_src    = {1'b0, r_idx} + {1'b0, r_shift};
    assign w_src_in = w_src < HP_EXT;

    // Magnitude of the running sum and signed average
    assign w_mag      = r_sum[SUM_W-1] ? (SUM_W'(0) - r_sum) : r_sum;
    assign w_q16      = w_div_q[VALUE_W-1:0];
    assign w_avg      = r_neg ? t_value'(VALUE_W'(0) - w_q16) : t_value'(w_q16);
    assign w_avg_done = (r_state == S_DIV_AVG) && w_div_done;

    // Shared divider operands
    assign w_div_start = (w_accept && (i_action == ACT_SAMPLE)) || (r_state == S_MAG);
    assign w_div_a     = (r_state == S_IDLE) ? w_elapsed : w_mag;
    assign w_div_b     = (r_state == S_IDLE) ? DIVISOR_W'(w_dur) : r_count;

    // History store port selection
    assign w_rd_addr = (r_state == S_SHIFT) ? w_src[IW-1:0] : IW'(i_read_slot);
    assign w_wr_en   = r_cp_vld || w_avg_done;
    assign w_wr_addr = r_cp_vld ? r_cp_dst : r_slot;
    assign w_wr_data = r_cp_vld ? (r_cp_fill ? r_marker : w_rd_value) : w_avg;

    tbah_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_div_start),
        .i_dividend (w_div_a),
        .i_divisor  (w_div_b),
        .o_quotient (w_div_q),
        .o_done     (w_div_done)
    );

    tbah_hist #(
        .HISTORY_POINTS (HISTORY_POINTS)
    ) u_hist (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_rd_addr (w_rd_addr),
        .i_wr_en   (w_wr_en),
        .i_wr_addr (w_wr_addr),
        .i_wr_data (w_wr_data),
        .o_rd_data (w_rd_value)
    );

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bin_seconds <= BIN_SECONDS_RESET;
            r_marker      <= RESET_MARKER;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                CFG_BIN_SECONDS:  r_bin_seconds <= i_cfg_data[BINSEC_W-1:0];
                CFG_UNDEF_MARKER: r_marker      <= t_value'(i_cfg_data);
                default:          r_marker      <= r_marker;
            endcase
        end
    end

    // Sequencer and running state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_started  <= 1'b0;
            r_origin   <= '0;
            r_prev_bin <= '0;
            r_sum      <= '0;
            r_count    <= '0;
            r_cp_vld   <= 1'b0;
            r_out_stb  <= 1'b0;
        end else begin
            r_out_stb <= 1'b0;
            r_cp_vld  <= 1'b0;
            case (r_state)
                S_IDLE: begin
                    if (w_accept) begin
                        if (i_action == ACT_READ) begin
                            r_state <= S_RDOUT;
                        end else begin
                            r_state <= S_DIV_BIN;
                            if (!r_started) begin
                                r_origin  <= i_time_sec;
                                r_started <= 1'b1;
                            end
                        end
                    end
                end
                S_RDOUT: begin
                    r_out_stb <= 1'b1;
                    r_state   <= S_IDLE;
                end
                S_DIV_BIN: begin
                    if (w_div_done) begin
                        r_state <= S_BIN;
                    end
                end
                S_BIN: begin
                    r_prev_bin <= r_bin;
                    if (w_adv) begin
                        r_sum   <= '0;
                        r_count <= '0;
                    end
                    r_state <= (w_adv && w_wide) ? S_SHIFT : S_ACC;
                end
                S_SHIFT: begin
                    // Copy an entry down, or fill a vacated slot
                    r_cp_vld <= 1'b1;
                    if (r_idx == COPY_END) begin
                        r_state <= S_ACC;
                    end
                end
                S_ACC: begin
                    if (r_count != '1) begin
                        r_sum   <= r_sum + SUM_W'(r_value);
                        r_count <= r_count + 1'b1;
                    end
                    r_state <= S_MAG;
                end
                S_MAG: begin
                    r_state <= S_DIV_AVG;
                end
                S_DIV_AVG: begin
                    if (w_div_done) begin
                        r_out_stb <= 1'b1;
                        r_state   <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    // Per-item payload registers
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_value   <= i_sample_value;
            r_rd_slot <= i_read_slot;
            r_rd_oor  <= 32'(i_read_slot) >= 32'(HISTORY_POINTS);
        end
        if (r_state == S_DIV_BIN && w_div_done) begin
            r_bin <= w_div_q;
        end
        if (r_state == S_BIN) begin
            r_shift <= (w_adv && w_wide) ? w_shift : '0;
            r_slot  <= w_wide ? LAST_IDX : r_bin[IW-1:0];
            r_idx   <= '0;
        end
        if (r_state == S_SHIFT) begin
            r_idx     <= r_idx + 1'b1;
            r_cp_dst  <= r_idx;
            r_cp_fill <= !w_src_in;
        end
        if (r_state == S_MAG) begin
            r_neg <= r_sum[SUM_W-1];
        end
        // Result payload
        if (r_state == S_RDOUT) begin
            r_out_slot  <= r_rd_slot;
            r_out_value <= r_rd_oor ? r_marker : w_rd_value;
            r_out_valid <= !r_rd_oor && (w_rd_value != r_marker);
            r_out_shift <= '0;
        end else if (w_avg_done) begin
            r_out_slot  <= SLOT_W'(r_slot);
            r_out_value <= w_avg;
            r_out_valid <= w_avg != r_marker;
            r_out_shift <= SLOT_W'(r_shift);
        end
    end

    assign o_result_strobe = r_out_stb;
    assign o_slot          = r_out_slot;
    assign o_point_value   = r_out_value;
    assign o_point_valid   = r_out_valid;
    assign o_shifted_by    = r_out_shift;

`ifndef SYNTHESIS
    // A result only follows a cycle of work
    a_result_after_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result_strobe |-> $past(busy))
        else $error("result strobe without preceding work");

    // A slide always writes the newest slot
    a_slide_slot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_result_strobe && o_shifted_by != '0) |-> (o_slot == SLOT_W'(HISTORY_POINTS - 1)))
        else $error("slide reported with a slot other than the last");

    // The divider finishes only while the sequencer waits for it
    a_div_done_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_div_done |-> (r_state == S_DIV_BIN || r_state == S_DIV_AVG))
        else $error("divider finished outside a divide state");

    // A taken command makes the block busy
    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> busy)
        else $error("command taken but block not busy");
`endif

endmodule

// File: tb/time_binned_average_history_checker.sv
// Checker for the time-binned average history: predicts every result and compares it.
`timescale 1ns / 1ps

module time_binned_average_history_checker
    import tbah_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    // Command channel
    input  logic               start,
    input  logic               busy,
    input  t_action            i_action,
    input  logic [TIME_W-1:0]  i_time_sec,
    input  t_value             i_sample_value,
    input  logic [SLOT_W-1:0]  i_read_slot,
    // Result channel
    input  logic               i_result_strobe,
    input  logic [SLOT_W-1:0]  i_slot,
    input  t_value             i_point_value,
    input  logic               i_point_valid,
    input  logic [SLOT_W-1:0]  i_shifted_by,
    // Configuration channel
    input  logic               i_cfg_valid,
    input  logic               i_cfg_ready,
    input  t_cfg_index         i_cfg_index,
    input  logic [VALUE_W-1:0] i_cfg_data,
    // Status for the testbench top
    output int                 o_fail_count,
    output int                 o_points_pending,
    output int                 o_points_checked
);

    localparam int NPOINTS = HISTORY_POINTS_DEF;

    typedef struct packed {
        logic [SLOT_W-1:0]  slot;
        logic [VALUE_W-1:0] value;
        logic               valid;
        logic [SLOT_W-1:0]  shift;
    } t_point;

    // Shadow copy of the block's state and registers
    logic [VALUE_W-1:0]      hist [NPOINTS];
    logic signed [SUM_W-1:0] bin_total;
    logic [COUNT_W-1:0]      bin_samples;
    logic [31:0]             last_bin;
    logic [TIME_W-1:0]       origin;
    bit                      have_origin;
    logic [BINSEC_W-1:0]     bin_secs;
    logic [VALUE_W-1:0]      marker;

    t_point predicted_points [$];
    int     fails_q  = 0;
    int     taken_q  = 0;
    int     seen_q   = 0;

    assign o_fail_count     = fails_q;
    assign o_points_pending = taken_q - seen_q;
    assign o_points_checked = seen_q;

    task automatic clear_history();
        int i;
        bin_secs = BIN_SECONDS_RESET;
        marker   = RESET_MARKER;
        for (i = 0; i < NPOINTS; i++)
            hist[i] = RESET_MARKER;
        bin_total   = '0;
        bin_samples = '0;
        last_bin    = '0;
        origin      = '0;
        have_origin = 1'b0;
    endtask

    // Work out the result of one command and update the shadow state
    task automatic predict_point(input t_action act, input logic [TIME_W-1:0] t,
                                 input t_value v, input logic [SLOT_W-1:0] rs,
                                 output t_point res);
        logic [31:0]        elapsed, dur, bin, shift, mag, q, wslot;
        logic [VALUE_W-1:0] avg;
        bit                 neg;
        int                 i;
        if (act == ACT_READ) begin
            res.slot  = rs;
            res.value = (rs < NPOINTS) ? hist[rs] : marker;
            res.shift = '0;
        end else begin
            if (!have_origin) begin
                origin      = t;
                have_origin = 1'b1;
            end
            elapsed = t - origin;
            dur     = (bin_secs == '0) ? 32'd1 : {24'd0, bin_secs};
            bin     = elapsed / dur;
            shift   = '0;
            // New bin: slide once past the end, then restart the running average
            if (bin > last_bin) begin
                if (bin >= NPOINTS) begin
                    shift = bin - last_bin;
                    if (shift > NPOINTS - 1)
                        shift = NPOINTS - 1;
                    for (i = 0; i < NPOINTS - shift; i++)
                        hist[i] = hist[i + shift];
                    for (i = NPOINTS - shift; i < NPOINTS - 1; i++)
                        hist[i] = marker;
                end
                bin_total   = '0;
                bin_samples = '0;
            end
            // Count saturates; the sum then freezes with it
            if (bin_samples != '1) begin
                bin_total   = bin_total + {{16{v[15]}}, v};
                bin_samples = bin_samples + 1'b1;
            end
            // Truncating division on magnitudes
            neg   = bin_total[SUM_W-1];
            mag   = neg ? (32'd0 - bin_total) : bin_total;
            q     = mag / {16'd0, bin_samples};
            avg   = neg ? (16'd0 - q[15:0]) : q[15:0];
            wslot = (bin < NPOINTS) ? bin : NPOINTS - 1;
            hist[wslot] = avg;
            last_bin    = bin;
            res.slot    = wslot[SLOT_W-1:0];
            res.value   = avg;
            res.shift   = shift[SLOT_W-1:0];
        end
        res.valid = (res.value != marker);
    endtask

    function automatic int field_miss(string name, int want, int got);
        if (want == got)
            return 0;
        $error("%s mismatch: expected %0d, actual %0d", name, want, got);
        return 1;
    endfunction

    // Watch the channels: register writes, results, then new commands
    always @(posedge i_clk) begin
        t_point want;
        t_point fresh;
        int     errs;
        errs = 0;
        if (!i_rst_n) begin
            clear_history();
            predicted_points.delete();
        end else begin
            if (i_cfg_valid && i_cfg_ready) begin
                case (i_cfg_index)
                    CFG_BIN_SECONDS:  bin_secs = i_cfg_data[BINSEC_W-1:0];
                    CFG_UNDEF_MARKER: marker   = i_cfg_data;
                    default: ;
                endcase
            end
            if (i_result_strobe) begin
                if (predicted_points.size() == 0) begin
                    errs++;
                    $error("result with nothing outstanding: slot %0d, point_value %0d",
                           i_slot, i_point_value);
                end else begin
                    want = predicted_points.pop_front();
                    errs += field_miss("slot", want.slot, i_slot);
                    errs += field_miss("point_value", $signed(want.value), i_point_value);
                    errs += field_miss("point_valid", want.valid, i_point_valid);
                    errs += field_miss("shifted_by", want.shift, i_shifted_by);
                end
                seen_q <= seen_q + 1;
            end
            if (start && !busy) begin
                predict_point(i_action, i_time_sec, i_sample_value, i_read_slot, fresh);
                predicted_points.push_back(fresh);
                taken_q <= taken_q + 1;
            end
        end
        fails_q <= fails_q + errs;
    end

endmodule

// File: tb/time_binned_average_history_tb.sv
// Testbench top for the time-binned average history: stimulus, register phases and verdict.
`timescale 1ns / 1ps

module time_binned_average_history_tb;
    import tbah_pkg::*;

    localparam int   CLK_HALF       = 10;
    localparam int   RESET_CYCLES   = 7;
    localparam int   MAX_GAP        = 13;
    localparam int   DRAIN_LIMIT    = 4000;
    localparam int   DRAIN_CYCLES   = 150;
    localparam int   RANDOM_PHASES  = 6;
    localparam int   PHASE_ITEMS    = 300;

    logic               i_clk          = 1'b0;
    logic               i_rst_n        = 1'b0;
    logic               start          = 1'b0;
    logic               busy;
    t_action            i_action       = ACT_SAMPLE;
    logic [TIME_W-1:0]  i_time_sec     = '0;
    t_value             i_sample_value = '0;
    logic [SLOT_W-1:0]  i_read_slot    = '0;
    logic               o_result_strobe;
    logic [SLOT_W-1:0]  o_slot;
    t_value             o_point_value;
    logic               o_point_valid;
    logic [SLOT_W-1:0]  o_shifted_by;
    logic               i_cfg_valid    = 1'b0;
    logic               o_cfg_ready;
    t_cfg_index         i_cfg_index    = CFG_BIN_SECONDS;
    logic [VALUE_W-1:0] i_cfg_data     = '0;

    int fail_count;
    int points_pending;
    int points_checked;

    int          samples_sent  = 0;
    int          reads_sent    = 0;
    int          settings_used = 0;
    bit          idle_on       = 1'b1;
    logic [31:0] bin_dur       = 32'd30;

    time_binned_average_history DUT (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .start           (start),
        .busy            (busy),
        .i_action        (i_action),
        .i_time_sec      (i_time_sec),
        .i_sample_value  (i_sample_value),
        .i_read_slot     (i_read_slot),
        .o_result_strobe (o_result_strobe),
        .o_slot          (o_slot),
        .o_point_value   (o_point_value),
        .o_point_valid   (o_point_valid),
        .o_shifted_by    (o_shifted_by),
        .i_cfg_valid     (i_cfg_valid),
        .o_cfg_ready     (o_cfg_ready),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data)
    );

    time_binned_average_history_checker u_checker (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .start            (start),
        .busy             (busy),
        .i_action         (i_action),
        .i_time_sec       (i_time_sec),
        .i_sample_value   (i_sample_value),
        .i_read_slot      (i_read_slot),
        .i_result_strobe  (o_result_strobe),
        .i_slot           (o_slot),
        .i_point_value    (o_point_value),
        .i_point_valid    (o_point_valid),
        .i_shifted_by     (o_shifted_by),
        .i_cfg_valid      (i_cfg_valid),
        .i_cfg_ready      (o_cfg_ready),
        .i_cfg_index      (i_cfg_index),
        .i_cfg_data       (i_cfg_data),
        .o_fail_count     (fail_count),
        .o_points_pending (points_pending),
        .o_points_checked (points_checked)
    );

    always #(CLK_HALF) i_clk = ~i_clk;

    // Watchdog: several times a full run with a slide and the longest gap on every sample
    initial begin
        #20_000_000;
        $display("Run timed out");
        $display("*** FAILED ***");
        $finish;
    end

    // One command transfer, after an optional random idle gap
    task automatic send_item(input t_action act, input logic [TIME_W-1:0] t,
                             input t_value v, input logic [SLOT_W-1:0] rs);
        int gap;
        gap = idle_on ? $urandom_range(0, MAX_GAP) : 0;
        if (gap != 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_action       <= act;
        i_time_sec     <= t;
        i_sample_value <= v;
        i_read_slot    <= rs;
        start          <= 1'b1;
        do @(posedge i_clk); while (busy);
        if (act == ACT_READ)
            reads_sent++;
        else
            samples_sent++;
    endtask

    // Let every outstanding result arrive and the block go quiet
    task automatic settle();
        int k;
        start <= 1'b0;
        for (k = 0; k < DRAIN_LIMIT && points_pending != 0; k++)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        while (busy) @(posedge i_clk);
    endtask

    // Both registers in back-to-back transfers; valid stays high between them
    task automatic write_cfg(input logic [BINSEC_W-1:0] secs, input t_value mark);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= CFG_BIN_SECONDS;
        i_cfg_data  <= {{(VALUE_W-BINSEC_W){1'b0}}, secs};
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_index <= CFG_UNDEF_MARKER;
        i_cfg_data  <= mark;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        bin_dur = (secs == '0) ? 32'd1 : {24'd0, secs};
        settings_used++;
    endtask

    initial begin
        logic [TIME_W-1:0] t0;
        logic [TIME_W-1:0] t_cur;
        t_value            v;
        int                p, n, r;

        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: empty history, first sample, bin edges, slides, wrap, time going back
        t0 = $urandom() | 32'h8000_0000;
        send_item(ACT_READ, $urandom(), t_value'($urandom()), 5'd0);
        send_item(ACT_READ, $urandom(), t_value'($urandom()), 5'd31);
        send_item(ACT_SAMPLE, t0, 16'sh7FFF, 5'd0);
        send_item(ACT_SAMPLE, t0 + 5, 16'sh8000, 5'd31);
        send_item(ACT_SAMPLE, t0 + 29, 16'sh0000, 5'd0);
        send_item(ACT_SAMPLE, t0 + 30, 16'sh8000, 5'd0);
        send_item(ACT_SAMPLE, t0 + 30 * 5 + 1, 16'sd100, 5'd0);
        send_item(ACT_SAMPLE, t0 + 30 * 2, -16'sd7, 5'd0);
        send_item(ACT_SAMPLE, t0 + 30 * 31, 16'sd1, 5'd0);
        send_item(ACT_SAMPLE, t0 + 30 * 32, 16'sd2, 5'd0);
        send_item(ACT_SAMPLE, t0 + 30 * 40, -16'sd1, 5'd0);
        send_item(ACT_SAMPLE, t0 + 30 * 200, 16'sd12345, 5'd0);
        send_item(ACT_SAMPLE, t0 - 1, -16'sd12345, 5'd0);
        send_item(ACT_SAMPLE, 32'h0000_0000, 16'sd0, 5'd0);
        send_item(ACT_SAMPLE, 32'hFFFF_FFFF, 16'sd5, 5'd0);
        send_item(ACT_READ, $urandom(), t_value'($urandom()), 5'd0);
        send_item(ACT_READ, $urandom(), t_value'($urandom()), 5'd15);
        send_item(ACT_READ, $urandom(), t_value'($urandom()), 5'd30);
        send_item(ACT_READ, $urandom(), t_value'($urandom()), 5'd31);

        // Zero bin duration behaves as one second; new marker fills vacated slots
        settle();
        write_cfg(8'd0, 16'sh7FFF);
        send_item(ACT_SAMPLE, t0 - 2, 16'sh7FFF, 5'd0);
        send_item(ACT_SAMPLE, t0 - 2, -16'sd1, 5'd0);
        send_item(ACT_READ, $urandom(), t_value'($urandom()), 5'd0);
        send_item(ACT_READ, $urandom(), t_value'($urandom()), 5'd30);
        send_item(ACT_READ, $urandom(), t_value'($urandom()), 5'd31);

        // Random phases, each under its own register setting
        t_cur = t0;
        for (p = 0; p < RANDOM_PHASES; p++) begin
            settle();
            case (p)
                0:       write_cfg(8'd1, 16'sh8000);
                1:       write_cfg(8'd255, 16'sh7FFF);
                2:       write_cfg(8'd30, 16'sh0000);
                3:       write_cfg(BINSEC_W'($urandom_range(1, 255)), t_value'($urandom()));
                4:       write_cfg(8'd0, t_value'($urandom()));
                default: write_cfg(BINSEC_W'($urandom_range(2, 20)), 16'sh8000);
            endcase
            for (n = 0; n < PHASE_ITEMS; n++) begin
                // Alternate stretches with and without idle gaps
                if (n % 64 == 0)
                    idle_on = ($urandom_range(0, 3) != 0);
                if ($urandom_range(0, 7) == 0) begin
                    case ($urandom_range(0, 3))
                        0:       v = 16'sh7FFF;
                        1:       v = 16'sh8000;
                        2:       v = 16'sh0000;
                        default: v = -16'sd1;
                    endcase
                end else begin
                    v = t_value'($urandom());
                end
                if ($urandom_range(0, 3) == 0) begin
                    send_item(ACT_READ, $urandom(), v, SLOT_W'($urandom_range(0, 31)));
                end else begin
                    // Mostly steady progress through bins, with jumps, rewinds and noise
                    r = $urandom_range(0, 99);
                    if (r < 60)
                        t_cur = t_cur + $urandom_range(0, 2 * bin_dur);
                    else if (r < 70)
                        t_cur = t_cur + $urandom_range(0, 40 * bin_dur);
                    else if (r < 85)
                        t_cur = t0 + $urandom_range(0, 40 * bin_dur);
                    else if (r < 90)
                        t_cur = t0 - $urandom_range(1, 4000);
                    else
                        t_cur = $urandom();
                    send_item(ACT_SAMPLE, t_cur, v, SLOT_W'($urandom_range(0, 31)));
                end
            end
        end

        settle();
        $display("Covered %0d samples and %0d reads across %0d register settings,",
                 samples_sent, reads_sent, settings_used);
        $display("with bin edges, slides, time wrap and rewinds; %0d results compared.",
                 points_checked);
        if (fail_count == 0 && points_pending == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule

// File: filelist.f
src/tbah_pkg.sv
src/tbah_div.sv
src/tbah_hist.sv
src/time_binned_average_history.sv
tb/time_binned_average_history_checker.sv
tb/time_binned_average_history_tb.sv
